// ----- rtl/pid_with_integral_leak_assert.svh -----
// Assertion macros shared by the PID controller RTL.
`ifndef PID_WITH_INTEGRAL_LEAK_ASSERT_SVH
`define PID_WITH_INTEGRAL_LEAK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PIDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PIDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pidl_pkg.sv -----
// Types, constants and microprogram of the leaky-integrator PID controller.
package pidl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 18;
  localparam int INTEG_W    = 20;
  localparam int DRIVE_W    = 16;
  localparam int LEAK_SHIFT = 16;
  localparam int OUT_SHIFT  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP             = 3'd0,
    REG_KI             = 3'd1,
    REG_KD             = 3'd2,
    REG_OUT_MAX        = 3'd3,
    REG_OUT_MIN        = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_ERROR_WINDOW   = 3'd6,
    REG_LEAK_FACTOR    = 3'd7
  } reg_idx_t;

  // Reset values: 1000.0 in Q.8, 15.0 in Q8.8, 0.98 in Q0.16
  localparam logic signed [GAIN_W-1:0] OUT_MAX_RST        = 16'sh7fff;
  localparam logic signed [GAIN_W-1:0] OUT_MIN_RST        = 16'sh8000;
  localparam logic [LIMIT_W-1:0]       INTEGRAL_LIMIT_RST = 18'd256000;
  localparam logic [15:0]              ERROR_WINDOW_RST   = 16'd3840;
  localparam logic [15:0]              LEAK_FACTOR_RST    = 16'd64225;

  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    INT_HOLD,
    INT_WINDOW,
    INT_CLAMP,
    INT_LEAK,
    INT_ZERO
  } integ_op_t;

  typedef enum logic [1:0] {
    MA_KP,
    MA_KI,
    MA_KD,
    MA_INT
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_ERR,
    MB_DIFF,
    MB_INT,
    MB_LEAK
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_KI_ZERO
  } jump_t;

  typedef struct packed {
    logic      ld_err;
    logic      ld_diff;
    integ_op_t integ_op;
    logic      mul_en;
    mul_a_t    mul_a;
    mul_b_t    mul_b;
    acc_op_t   acc_op;
    jump_t     jmp;
    step_t     target;
    logic      fin;
  } ctl_word_t;

  localparam step_t ST_ERR     = 4'd0;
  localparam step_t ST_DIFF    = 4'd1;
  localparam step_t ST_WINDOW  = 4'd2;
  localparam step_t ST_CLAMP   = 4'd3;
  localparam step_t ST_LEAKMUL = 4'd4;
  localparam step_t ST_LEAK    = 4'd5;
  localparam step_t ST_ZERO    = 4'd6;
  localparam step_t ST_PMUL    = 4'd7;
  localparam step_t ST_IMUL    = 4'd8;
  localparam step_t ST_DMUL    = 4'd9;
  localparam step_t ST_LASTADD = 4'd10;
  localparam step_t ST_FIN     = 4'd11;

  localparam ctl_word_t CTL_NOP = '{
    ld_err: 1'b0, ld_diff: 1'b0, integ_op: INT_HOLD, mul_en: 1'b0,
    mul_a: MA_KP, mul_b: MB_ERR, acc_op: ACC_HOLD, jmp: JMP_NONE,
    target: ST_ERR, fin: 1'b0
  };

  // Microprogram ROM
  function automatic ctl_word_t ucode(step_t s);
    ctl_word_t w;
    w = CTL_NOP;
    unique case (s)
      ST_ERR:     w.ld_err = 1'b1;
      ST_DIFF: begin
        w.ld_diff = 1'b1;
        w.jmp     = JMP_KI_ZERO;
        w.target  = ST_ZERO;
      end
      ST_WINDOW:  w.integ_op = INT_WINDOW;
      ST_CLAMP:   w.integ_op = INT_CLAMP;
      ST_LEAKMUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_INT;
        w.mul_b  = MB_LEAK;
      end
      ST_LEAK: begin
        w.integ_op = INT_LEAK;
        w.jmp      = JMP_ALWAYS;
        w.target   = ST_PMUL;
      end
      ST_ZERO:    w.integ_op = INT_ZERO;
      ST_PMUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_KP;
        w.mul_b  = MB_ERR;
        w.acc_op = ACC_CLEAR;
      end
      ST_IMUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_KI;
        w.mul_b  = MB_INT;
        w.acc_op = ACC_ADD;
      end
      ST_DMUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_KD;
        w.mul_b  = MB_DIFF;
        w.acc_op = ACC_ADD;
      end
      ST_LASTADD: w.acc_op = ACC_ADD;
      ST_FIN:     w.fin = 1'b1;
      default:    w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/pidl_if.sv -----
// Valid/ready channel interfaces: samples in, drive out, register writes.
interface pidl_sample_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, target, measured, input ready);
  modport sink   (input valid, target, measured, output ready);
endinterface

interface pidl_drive_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pidl_pkg::DRIVE_W-1:0]  drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pidl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pidl_pkg::CFG_IDX_W-1:0]   index;
  logic [pidl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pid_with_integral_leak.sv -----
// PID controller with windowed, clamped and leaky integral; top level.
//
// One sample transaction yields one drive transaction. After a sample is taken the
// block runs a short microprogram on one shared multiplier and accumulator, which
// ends in a registered drive; when ki is zero the window, clamp and leak steps give
// way to one clearing step. A new sample is taken in the cycle after the program
// ends, even while the previous drive still waits; the last step holds only if the
// drive register is still full. No new sample is taken while the program runs, so
// the sustained rate is set by the length of the program, and is lower while the
// drive is held off. Registers are written through the cfg channel, which is ready
// whenever the block is out of reset, and must only be written while no sample is
// in flight.
`include "pid_with_integral_leak_assert.svh"

module pid_with_integral_leak #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  pidl_sample_if.sink     sample,
  pidl_drive_if.source    result,
  pidl_cfg_if.sink        cfg
);

  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int IW     = pidl_pkg::INTEG_W;
  localparam int BW     = (DIFF_W > IW) ? DIFF_W : IW;
  localparam int PW     = IW + BW;
  localparam int CW     = ((ERR_W > 17) ? ERR_W : 17) + 1;
  localparam int SUMW   = ((ERR_W > IW) ? ERR_W : IW) + 1;

  // configuration registers
  logic signed [pidl_pkg::GAIN_W-1:0]  kp, ki, kd, out_max, out_min;
  logic        [pidl_pkg::LIMIT_W-1:0] int_limit;
  logic        [15:0]                  err_window;
  logic        [15:0]                  leak_factor;

  // datapath
  logic signed [SAMPLE_WIDTH-1:0] tgt_q, meas_q;
  logic signed [ERR_W-1:0]        err_q, prev_err;
  logic signed [DIFF_W-1:0]       diff_q;
  logic signed [IW-1:0]           integ;
  logic signed [PW-1:0]           prod_q, acc;
  logic signed [IW-1:0]           a_op;
  logic signed [BW-1:0]           b_op;
  logic signed [PW-1:0]           mul_out;
  logic signed [CW-1:0]           err_c, win_c;
  logic                           in_window;
  logic signed [SUMW-1:0]         win_sum;
  logic signed [IW-1:0]           lim_s, lim_neg;
  logic signed [PW-1:0]           y_full, y_hi, y_lo;
  logic                           drive_valid;
  logic signed [pidl_pkg::DRIVE_W-1:0] drive_q;

  logic                           in_accept;
  logic                           busy, exec, write_out;
  pidl_pkg::ctl_word_t            ctl;

  assign in_accept    = sample.valid && sample.ready;
  assign sample.ready = !busy && !rst;
  assign cfg.ready    = !rst;
  assign result.valid = drive_valid;
  assign result.drive = drive_q;
  assign write_out    = exec && ctl.fin;

  pidl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .ki_zero  (ki == '0),
    .out_busy (drive_valid && !result.ready),
    .busy     (busy),
    .exec     (exec),
    .ctl      (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= '0;
      ki          <= '0;
      kd          <= '0;
      out_max     <= pidl_pkg::OUT_MAX_RST;
      out_min     <= pidl_pkg::OUT_MIN_RST;
      int_limit   <= pidl_pkg::INTEGRAL_LIMIT_RST;
      err_window  <= pidl_pkg::ERROR_WINDOW_RST;
      leak_factor <= pidl_pkg::LEAK_FACTOR_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (pidl_pkg::reg_idx_t'(cfg.index))
        pidl_pkg::REG_KP:             kp          <= cfg.data[15:0];
        pidl_pkg::REG_KI:             ki          <= cfg.data[15:0];
        pidl_pkg::REG_KD:             kd          <= cfg.data[15:0];
        pidl_pkg::REG_OUT_MAX:        out_max     <= cfg.data[15:0];
        pidl_pkg::REG_OUT_MIN:        out_min     <= cfg.data[15:0];
        pidl_pkg::REG_INTEGRAL_LIMIT: int_limit   <= cfg.data;
        pidl_pkg::REG_ERROR_WINDOW:   err_window  <= cfg.data[15:0];
        pidl_pkg::REG_LEAK_FACTOR:    leak_factor <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (ctl.mul_a)
      pidl_pkg::MA_KP:  a_op = IW'(kp);
      pidl_pkg::MA_KI:  a_op = IW'(ki);
      pidl_pkg::MA_KD:  a_op = IW'(kd);
      default:          a_op = integ;
    endcase
    unique case (ctl.mul_b)
      pidl_pkg::MB_ERR:  b_op = BW'(err_q);
      pidl_pkg::MB_DIFF: b_op = BW'(diff_q);
      pidl_pkg::MB_INT:  b_op = BW'(integ);
      default:           b_op = BW'($signed({1'b0, leak_factor}));
    endcase
  end

  assign mul_out = PW'(a_op) * PW'(b_op);

  // |err| < window, tested as -window < err < window
  assign err_c     = CW'(err_q);
  assign win_c     = CW'($signed({1'b0, err_window}));
  assign in_window = (err_c < win_c) && (err_c > -win_c);
  // only taken inside the window, so the sum fits the integral register width
  assign win_sum   = SUMW'(integ) + SUMW'(err_q);
  assign lim_s     = IW'($signed({1'b0, int_limit}));
  assign lim_neg   = -lim_s;

  // floor shift of the sum, then upper and lower limits (lower wins)
  assign y_full = acc >>> pidl_pkg::OUT_SHIFT;
  assign y_hi   = (y_full > PW'(out_max)) ? PW'(out_max) : y_full;
  assign y_lo   = (y_hi < PW'(out_min)) ? PW'(out_min) : y_hi;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tgt_q  <= sample.target;
      meas_q <= sample.measured;
    end
    if (exec) begin
      if (ctl.ld_err) begin
        err_q <= ERR_W'(tgt_q) - ERR_W'(meas_q);
      end
      if (ctl.ld_diff) begin
        diff_q <= DIFF_W'(err_q) - DIFF_W'(prev_err);
      end
      if (ctl.mul_en) begin
        prod_q <= mul_out;
      end
      unique case (ctl.acc_op)
        pidl_pkg::ACC_CLEAR: acc <= '0;
        pidl_pkg::ACC_ADD:   acc <= acc + prod_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else if (exec) begin
      if (ctl.ld_diff) begin
        prev_err <= err_q;
      end
      unique case (ctl.integ_op)
        pidl_pkg::INT_WINDOW: begin
          if (in_window) begin
            integ <= win_sum[IW-1:0];
          end
        end
        pidl_pkg::INT_CLAMP: begin
          if (integ > lim_s) begin
            integ <= lim_s;
          end else if (integ < lim_neg) begin
            integ <= lim_neg;
          end
        end
        pidl_pkg::INT_LEAK: integ <= prod_q[pidl_pkg::LEAK_SHIFT +: IW];
        pidl_pkg::INT_ZERO: integ <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (write_out) begin
      drive_valid <= 1'b1;
    end else if (result.ready) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_out) begin
      drive_q <= y_lo[pidl_pkg::DRIVE_W-1:0];
    end
  end

  `PIDL_ASSERT_NEXT(a_drive_loaded, write_out, result.valid, "drive not presented after final step")
  `PIDL_ASSERT_NOW(a_ki_zero_clears, write_out && (ki == '0), integ == '0, "integral not cleared with zero ki")
  `PIDL_ASSERT_NOW(a_integ_bounded, write_out, (integ <= lim_s) && (integ >= lim_neg), "integral beyond its limit")
  `PIDL_ASSERT_NOW(a_prev_err_kept, write_out, prev_err == err_q, "previous error not updated")

endmodule

// ----- rtl/pidl_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
module pidl_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  ki_zero,
  input  logic                  out_busy,
  output logic                  busy,
  output logic                  exec,
  output pidl_pkg::ctl_word_t   ctl
);

  pidl_pkg::step_t step;
  pidl_pkg::step_t step_next;
  logic            busy_next;
  logic            stall;
  logic            take_jump;

  always_comb begin
    ctl   = pidl_pkg::ucode(step);
    stall = ctl.fin && out_busy;
    exec  = busy && !stall;
  end

  always_comb begin
    unique case (ctl.jmp)
      pidl_pkg::JMP_ALWAYS:  take_jump = 1'b1;
      pidl_pkg::JMP_KI_ZERO: take_jump = ki_zero;
      default:               take_jump = 1'b0;
    endcase
  end

  always_comb begin
    step_next = step;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        step_next = pidl_pkg::ST_ERR;
        busy_next = 1'b1;
      end
    end else if (!stall) begin
      if (ctl.fin) begin
        step_next = pidl_pkg::ST_ERR;
        busy_next = 1'b0;
      end else if (take_jump) begin
        step_next = ctl.target;
      end else begin
        step_next = step + pidl_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= pidl_pkg::ST_ERR;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule
